### sv/mtwg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtwg_pkg
// Constants, state encoding and word functions for the MT19937 word unit.
// ----------------------------------------------------------------------------
package mtwg_pkg;

  localparam int unsigned N_WORDS    = 624;
  localparam int unsigned IDX_W      = 10;
  localparam logic [IDX_W-1:0] IDX_LAST   = 10'd623;
  localparam logic [IDX_W-1:0] SHIFT_M    = 10'd397;
  localparam logic [IDX_W-1:0] WRAP_M     = 10'd227;   // N - M

  localparam logic [31:0] TWIST_FEEDBACK = 32'h9908_b0df;
  localparam logic [31:0] MSB_KEEP       = 32'h8000_0000;
  localparam logic [31:0] LSB31_KEEP     = 32'h7fff_ffff;
  localparam logic [31:0] SEED_MULT      = 32'd1812433253;
  localparam logic [31:0] DEFAULT_SEED   = 32'd5489;
  localparam logic [31:0] TEMPER_B       = 32'h9d2c_5680;
  localparam logic [31:0] TEMPER_C       = 32'hefc6_0000;

  localparam logic OP_GENERATE = 1'b0;
  localparam logic OP_SEED     = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED_MUL,
    ST_SEED_ADD,
    ST_GEN_RD,
    ST_GEN_WR
  } mtwg_state_t;

  function automatic logic [31:0] twist_word(input logic [31:0] cur,
                                             input logic [31:0] nxt,
                                             input logic [31:0] far);
    logic [31:0] y;
    logic [31:0] r;
    y = (cur & MSB_KEEP) | (nxt & LSB31_KEEP);
    r = far ^ (y >> 1);
    if (y[0]) begin
      r = r ^ TWIST_FEEDBACK;
    end
    return r;
  endfunction

  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

### sv/mt19937_word_generator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mt19937_word_generator_unit
// MT19937 word source: 624-word state in a synchronous memory, twisted
// lazily one word per generate item.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): in_opcode selects generate (0) or seed
// (1, from in_seed_value). Output channel (out_valid/out_ready) carries one
// tempered word per generate item; a seed item gives nothing.
// A generate item runs ST_GEN_RD, which reads the next word and the word
// 397 places ahead from the two memory read ports, then ST_GEN_WR, which
// twists the current word, writes it back and tempers it into the output
// register. No new item is taken until the unit is back in ST_IDLE after
// ST_GEN_WR. The current word is kept in a register, taken from the
// previous step's read, so each step needs only two reads.
// A seed item writes word 0 on acceptance, then each of the other 623 words
// in turn (registered multiply in ST_SEED_MUL, then add and write in
// ST_SEED_ADD), as every word depends on the one before.
// A generate before any seed runs the seeding with 5489 first.
// Reset clears the control state and marks the unit unseeded; memory
// contents are not cleared. Input is taken only while the unit is idle; if
// the receiver stalls, a finished word waits in the output register and
// the next generate holds before its write-back until that word is taken.
// ----------------------------------------------------------------------------
module mt19937_word_generator_unit
  import mtwg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [31:0] in_seed_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_random_word
);

  logic [31:0] mem [N_WORDS];

  mtwg_state_t      state_r, state_nxt;
  logic             seeded_r, seeded_nxt;
  logic             gen_pend_r, gen_pend_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic [31:0]      cur_r, cur_nxt;
  logic [31:0]      prev_r, prev_nxt;
  logic [31:0]      prod_r, prod_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [31:0]      out_word_r, out_word_nxt;

  logic             we;
  logic [IDX_W-1:0] waddr;
  logic [31:0]      wdata;
  logic             re;
  logic [IDX_W-1:0] raddr_a, raddr_b;
  logic [31:0]      rd_a_r, rd_b_r;

  logic [31:0]      twisted;
  logic [31:0]      seed_word;
  logic [31:0]      seed_mix;

  assign in_ready        = (state_r == ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_random_word = out_word_r;

  assign raddr_a   = (idx_r == IDX_LAST) ? '0 : idx_r + 10'd1;
  assign raddr_b   = (idx_r < WRAP_M) ? idx_r + SHIFT_M : idx_r - WRAP_M;
  assign twisted   = twist_word(cur_r, rd_a_r, rd_b_r);
  assign seed_word = prod_r + {{(32-IDX_W){1'b0}}, cnt_r};
  assign seed_mix  = prev_r ^ (prev_r >> 30);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_a_r <= mem[raddr_a];
      rd_b_r <= mem[raddr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      seeded_r    <= 1'b0;
      gen_pend_r  <= 1'b0;
      idx_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seeded_r    <= seeded_nxt;
      gen_pend_r  <= gen_pend_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    prev_r     <= prev_nxt;
    prod_r     <= prod_nxt;
    out_word_r <= out_word_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    seeded_nxt    = seeded_r;
    gen_pend_nxt  = gen_pend_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    prod_nxt      = prod_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r && !out_ready;
    we            = 1'b0;
    waddr         = cnt_r;
    wdata         = seed_word;
    re            = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_opcode == OP_SEED || !seeded_r) begin
            // word 0 is the seed itself; it also primes the current-word register
            we           = 1'b1;
            waddr        = '0;
            wdata        = (in_opcode == OP_SEED) ? in_seed_value : DEFAULT_SEED;
            prev_nxt     = wdata;
            cur_nxt      = wdata;
            cnt_nxt      = 10'd1;
            idx_nxt      = '0;
            seeded_nxt   = 1'b1;
            gen_pend_nxt = (in_opcode == OP_GENERATE);
            state_nxt    = ST_SEED_MUL;
          end else begin
            state_nxt = ST_GEN_RD;
          end
        end
      end
      ST_SEED_MUL: begin
        prod_nxt  = SEED_MULT * seed_mix;
        state_nxt = ST_SEED_ADD;
      end
      ST_SEED_ADD: begin
        we       = 1'b1;
        waddr    = cnt_r;
        wdata    = seed_word;
        prev_nxt = seed_word;
        if (cnt_r == IDX_LAST) begin
          cnt_nxt      = '0;
          gen_pend_nxt = 1'b0;
          state_nxt    = gen_pend_r ? ST_GEN_RD : ST_IDLE;
        end else begin
          cnt_nxt   = cnt_r + 10'd1;
          state_nxt = ST_SEED_MUL;
        end
      end
      ST_GEN_RD: begin
        re        = 1'b1;
        state_nxt = ST_GEN_WR;
      end
      ST_GEN_WR: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          we            = 1'b1;
          waddr         = idx_r;
          wdata         = twisted;
          out_word_nxt  = temper(twisted);
          out_valid_nxt = 1'b1;
          cur_nxt       = rd_a_r;
          idx_nxt       = (idx_r == IDX_LAST) ? '0 : idx_r + 10'd1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### bench/mt19937_word_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mt19937_word_checker
// Watches both item channels of the MT19937 word unit, keeps its own copy of
// the generator state, predicts every tempered word and compares in order.
// ----------------------------------------------------------------------------
module mt19937_word_checker
  import mtwg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_opcode,
  input  logic [31:0] in_seed_value,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_random_word,
  output int          fail_count,
  output int          backlog
);

  logic [31:0] gen_words [N_WORDS];
  int unsigned read_pos;
  bit          has_seed;
  logic [31:0] expected_words [$];

  function automatic void load_seed(input logic [31:0] seed);
    logic [31:0] prev;
    gen_words[0] = seed;
    for (int i = 1; i < N_WORDS; i++) begin
      prev         = gen_words[i-1];
      gen_words[i] = SEED_MULT * (prev ^ (prev >> 30)) + 32'(i);
    end
    read_pos = N_WORDS;
    has_seed = 1'b1;
  endfunction

  function automatic logic [31:0] next_state_word(input logic [31:0] cur,
                                                  input logic [31:0] nxt,
                                                  input logic [31:0] far);
    logic [31:0] joined;
    joined = {cur[31], nxt[30:0]};
    return far ^ (joined >> 1) ^ (joined[0] ? TWIST_FEEDBACK : 32'h0);
  endfunction

  // whole-state twist; later words already see the fresh early ones
  function automatic void regenerate();
    for (int k = 0; k < N_WORDS; k++) begin
      gen_words[k] = next_state_word(gen_words[k], gen_words[(k + 1) % N_WORDS],
                                     gen_words[(k + int'(SHIFT_M)) % N_WORDS]);
    end
  endfunction

  function automatic logic [31:0] temper_word(input logic [31:0] raw);
    logic [31:0] t;
    t = raw ^ (raw >> 11);
    t = t ^ ((t << 7) & TEMPER_B);
    t = t ^ ((t << 15) & TEMPER_C);
    return t ^ (t >> 18);
  endfunction

  function automatic logic [31:0] predict_word();
    logic [31:0] raw;
    if (!has_seed) begin
      load_seed(DEFAULT_SEED);
    end
    if (read_pos >= N_WORDS) begin
      regenerate();
      read_pos = 0;
    end
    raw      = gen_words[read_pos];
    read_pos = read_pos + 1;
    return temper_word(raw);
  endfunction

  always @(posedge clk) begin : watch
    logic [31:0] want;
    if (!rst_n) begin
      expected_words.delete();
      read_pos   = N_WORDS;
      has_seed   = 1'b0;
      fail_count <= 0;
    end else begin
      // output first: a word leaving now never belongs to an item taken now
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: word %h with none expected", $time, out_random_word);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_words.pop_front();
          if (out_random_word !== want) begin
            $display("%0t: random_word mismatch: expected %h, got %h",
                     $time, want, out_random_word);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (in_opcode == OP_SEED) begin
          load_seed(in_seed_value);
        end else begin
          expected_words.push_back(predict_word());
        end
      end
    end
    backlog <= expected_words.size();
  end

endmodule

### bench/mt19937_word_generator_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mt19937_word_generator_unit_test
// Drives seed and generate items into the MT19937 word unit with random gaps
// and output stalls; the checker beside it predicts and compares each word.
// ----------------------------------------------------------------------------
module mt19937_word_generator_unit_test
  import mtwg_pkg::*;
;

  localparam int LONG_HOLD    = 300;
  localparam int IDLE_LIMIT   = 10000;
  localparam int SEED_LATENCY = 1300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_opcode = OP_GENERATE;
  logic [31:0] in_seed_value = 32'h0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_random_word;

  int fail_count;
  int backlog;
  bit tx_idling = 1'b1;
  bit rx_idling = 1'b1;
  bit hold_req  = 1'b0;
  bit hold_done = 1'b0;
  int n_gen     = 0;
  int n_seed    = 0;
  int quiet_cycles = 0;
  int stall_left   = 0;

  mt19937_word_generator_unit uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_seed_value   (in_seed_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_random_word (out_random_word)
  );

  mt19937_word_checker word_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_seed_value   (in_seed_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_random_word (out_random_word),
    .fail_count      (fail_count),
    .backlog         (backlog)
  );

  always #6 clk = ~clk;

  // receiver: short random stalls, or one long hold-off on request
  always @(posedge clk) begin
    if (stall_left == 0) begin
      if (hold_req && !hold_done) begin
        hold_done  = 1'b1;
        stall_left = LONG_HOLD;
      end else if (rx_idling && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 19);
      end
    end
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_item(input logic op, input logic [31:0] seed);
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_seed_value <= seed;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op == OP_SEED) n_seed++;
    else n_gen++;
    if (tx_idling && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic send_random(input int seed_odds);
    logic op;
    op = ($urandom_range(0, seed_odds - 1) == 0) ? OP_SEED : OP_GENERATE;
    send_item(op, $urandom());
  endtask

  // drop in_valid and let the checker see the last accepted item, then wait on the backlog
  task automatic drain_words();
    in_valid <= 1'b0;
    @(posedge clk);
    while (backlog != 0) @(posedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // unseeded start falls back to the default seed
    repeat (3) send_item(OP_GENERATE, $urandom());
    // reseed mid-sequence with the default restarts the same stream
    send_item(OP_SEED, DEFAULT_SEED);
    repeat (2) send_item(OP_GENERATE, $urandom());
    send_item(OP_SEED, 32'h0000_0000);
    repeat (2) send_item(OP_GENERATE, 32'hffff_ffff);
    send_item(OP_SEED, 32'hffff_ffff);
    repeat (2) send_item(OP_GENERATE, 32'h0000_0000);
    send_item(OP_SEED, 32'h0000_0001);
    send_item(OP_GENERATE, $urandom());
    send_item(OP_SEED, 32'h8000_0000);
    send_item(OP_GENERATE, $urandom());
    send_item(OP_GENERATE, $urandom());
    // back-to-back seeds: only the second counts
    send_item(OP_SEED, 32'h1234_5678);
    send_item(OP_SEED, 32'hdead_beef);
    send_item(OP_GENERATE, $urandom());
    send_item(OP_SEED, $urandom());

    // one unbroken run past the 624-word twist boundary
    for (int i = 0; i < 628; i++) begin
      if (i % 128 == 0) begin
        tx_idling = 1'($urandom_range(0, 1));
        rx_idling = 1'($urandom_range(0, 1));
      end
      if (i == 200) begin
        // long receiver hold while items keep coming: input must back up
        tx_idling = 1'b0;
        hold_req  = 1'b1;
      end
      send_item(OP_GENERATE, $urandom());
    end
    drain_words();

    tx_idling = 1'b1;
    rx_idling = 1'b1;
    for (int i = 0; i < 16; i++) begin
      if (i % 8 == 7) begin
        tx_idling = 1'($urandom_range(0, 1));
        rx_idling = 1'($urandom_range(0, 1));
      end
      send_random(8);
    end

    // closing stretch at full rate
    tx_idling = 1'b0;
    rx_idling = 1'b0;
    for (int i = 0; i < 20; i++) begin
      send_random(16);
    end
    send_item(OP_GENERATE, $urandom());
    drain_words();
    repeat (SEED_LATENCY) @(posedge clk);

    $display("Covered %0d generate and %0d seed items, with a run across the twist",
             n_gen, n_seed);
    $display("boundary, a %0d-cycle output hold-off and random gaps on both sides.",
             LONG_HOLD);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
